@@ src/sat_pkg.sv @@
package sat_pkg;

    // grid size
    localparam int ROWS = 16;
    localparam int COLS = 16;

    // fixed field widths
    localparam int FW     = 4;
    localparam int CELL_W = 8;
    localparam int SUM_W  = 16;

    // table geometry, one extra zero row and column
    localparam int PSTRIDE = COLS + 1;
    localparam int CDEPTH  = ROWS * COLS;
    localparam int PDEPTH  = (ROWS + 1) * (COLS + 1);
    localparam int RIW     = $clog2(ROWS + 1);
    localparam int CIW     = $clog2(COLS + 1);
    localparam int CAW     = ($clog2(CDEPTH) > 0) ? $clog2(CDEPTH) : 1;
    localparam int PAW     = $clog2(PDEPTH);

    // table entry width: exact for a full-grid sum of extreme cells
    localparam int PW = CELL_W + 1 + $clog2(CDEPTH);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ALU_HOLD = 3'd0,
        ALU_CLR  = 3'd1,
        ALU_LOAD = 3'd2,
        ALU_ADD  = 3'd3,
        ALU_SUB  = 3'd4
    } alu_op_t;

    // control from the sequencer to the shared adder
    typedef struct packed {
        alu_op_t         op;
        logic [PW-1:0]   operand;
    } alu_ctl_t;

    // table address of entry (r, c)
    function automatic logic [PAW-1:0] prefix_addr(input logic [RIW-1:0] r,
                                                   input logic [CIW-1:0] c);
        int a;
        a = int'(r) * PSTRIDE + int'(c);
        return a[PAW-1:0];
    endfunction

    // cell address of (r, c)
    function automatic logic [CAW-1:0] cell_addr(input logic [RIW-1:0] r,
                                                 input logic [CIW-1:0] c);
        int a;
        a = int'(r) * COLS + int'(c);
        return a[CAW-1:0];
    endfunction

    // saturate a row coordinate at ROWS
    function automatic logic [RIW-1:0] clamp_row(input logic [FW:0] v);
        int t;
        t = int'(v);
        if (t > ROWS) begin
            t = ROWS;
        end
        return t[RIW-1:0];
    endfunction

    // saturate a column coordinate at COLS
    function automatic logic [CIW-1:0] clamp_col(input logic [FW:0] v);
        int t;
        t = int'(v);
        if (t > COLS) begin
            t = COLS;
        end
        return t[CIW-1:0];
    endfunction

    // sign extend a cell to table width
    function automatic logic [PW-1:0] cell_ext(input logic [CELL_W-1:0] v);
        logic signed [PW+CELL_W-1:0] w;
        w = signed'(v);
        return w[PW-1:0];
    endfunction

    // wrap or extend a table-width sum to the result width
    function automatic logic [SUM_W-1:0] sum_wrap(input logic [PW-1:0] v);
        logic signed [PW+SUM_W-1:0] w;
        w = signed'(v);
        return w[SUM_W-1:0];
    endfunction

endpackage

@@ src/summed_area_table_engine_unit.sv @@
// Summed-area table engine: a 16 x 16 grid of signed 8-bit cells and its
// 2D prefix-sum table, driven by a command stream.
// Input beats (s_) carry an opcode in s_tuser: write one cell, build the
// table, or query an inclusive rectangle. Only a query returns a beat on the
// master side (m_): the 16-bit rectangle sum in m_tdata and, in m_tuser,
// whether no write has happened since the last build.
// After reset a clearing pass zeroes both memories, one entry a cycle, and
// s_tready stays low until it is done.
// Command timing is set by the single-port table memory and one shared adder:
//   write: the next beat is taken in the following cycle
//   query: four table reads, then the accumulate, then the result register,
//          which waits while an earlier result is held; then back to idle
//   build: states BUP, BDG, BSUB, BADD and BWR for each table entry in turn
// One command is in work at a time; s_tready is high only when idle.
// The result sits in an output register, so a new command is taken while an
// earlier result waits; a query that finishes while m_tready is held low
// waits with its result until the register is free.
module summed_area_table_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_a, col_a, row_b, col_b, cell_value
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // rect_sum
    output logic        m_tuser    // table_current
);

    localparam int RIW = sat_pkg::RIW;
    localparam int CIW = sat_pkg::CIW;
    localparam int PAW = sat_pkg::PAW;
    localparam int CAW = sat_pkg::CAW;
    localparam int PW  = sat_pkg::PW;
    localparam int FW  = sat_pkg::FW;

    localparam logic [RIW-1:0] ROW_LAST = RIW'(sat_pkg::ROWS);
    localparam logic [CIW-1:0] COL_LAST = CIW'(sat_pkg::COLS);
    localparam logic [RIW-1:0] ROW_ONE  = RIW'(1);
    localparam logic [CIW-1:0] COL_ONE  = CIW'(1);
    localparam logic [PAW-1:0] CLR_LAST = PAW'(sat_pkg::PDEPTH - 1);

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_QRD0  = 13'b0000000000100,
        ST_QRD1  = 13'b0000000001000,
        ST_QRD2  = 13'b0000000010000,
        ST_QRD3  = 13'b0000000100000,
        ST_QADD  = 13'b0000001000000,
        ST_QDONE = 13'b0000010000000,
        ST_BUP   = 13'b0000100000000,
        ST_BDG   = 13'b0001000000000,
        ST_BSUB  = 13'b0010000000000,
        ST_BADD  = 13'b0100000000000,
        ST_BWR   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [PAW-1:0] clr_reg, clr_next;
    logic [RIW-1:0] r1_reg, r1_next, r2_reg, r2_next, br_reg, br_next;
    logic [CIW-1:0] c1_reg, c1_next, c2_reg, c2_next, bc_reg, bc_next;
    logic           built_reg, built_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [15:0]    m_sum_reg, m_sum_next;
    logic           m_cur_reg, m_cur_next;

    // input beat fields
    sat_pkg::opcode_t in_op;
    logic [FW-1:0]    row_a, col_a, row_b, col_b;
    logic [7:0]       cell_value;
    logic             s_accept;
    logic             wr_in_range;

    // memory and adder controls
    logic             p_we, p_re;
    logic [PAW-1:0]   p_addr;
    logic [PW-1:0]    p_wdata, p_rdata;
    logic             c_we, c_re;
    logic [CAW-1:0]   c_addr;
    logic [7:0]       c_wdata, c_rdata;
    sat_pkg::alu_ctl_t alu_ctl;
    logic [PW-1:0]    acc;
    logic [RIW-1:0]   br_prev;
    logic [CIW-1:0]   bc_prev;

    assign in_op      = sat_pkg::opcode_t'(s_tuser);
    assign row_a      = s_tdata[3:0];
    assign col_a      = s_tdata[7:4];
    assign row_b      = s_tdata[11:8];
    assign col_b      = s_tdata[15:12];
    assign cell_value = s_tdata[23:16];

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign wr_in_range = (row_a < sat_pkg::ROWS) && (col_a < sat_pkg::COLS);
    assign br_prev     = br_reg - ROW_ONE;
    assign bc_prev     = bc_reg - COL_ONE;

    // cell grid
    sat_ram #(.WIDTH(sat_pkg::CELL_W), .DEPTH(sat_pkg::CDEPTH)) u_cell_ram (
        .aclk    (aclk),
        .we      (c_we),
        .re      (c_re),
        .addr    (c_addr),
        .wr_data (c_wdata),
        .rd_data (c_rdata)
    );

    // prefix-sum table
    sat_ram #(.WIDTH(PW), .DEPTH(sat_pkg::PDEPTH)) u_prefix_ram (
        .aclk    (aclk),
        .we      (p_we),
        .re      (p_re),
        .addr    (p_addr),
        .wr_data (p_wdata),
        .rd_data (p_rdata)
    );

    // shared accumulator
    sat_alu u_alu (
        .aclk (aclk),
        .ctl  (alu_ctl),
        .acc  (acc)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        r1_next       = r1_reg;
        c1_next       = c1_reg;
        r2_next       = r2_reg;
        c2_next       = c2_reg;
        br_next       = br_reg;
        bc_next       = bc_reg;
        built_next    = built_reg;
        m_tvalid_next = m_tvalid_reg;
        m_sum_next    = m_sum_reg;
        m_cur_next    = m_cur_reg;

        p_we    = 1'b0;
        p_re    = 1'b0;
        p_addr  = '0;
        p_wdata = acc;
        c_we    = 1'b0;
        c_re    = 1'b0;
        c_addr  = '0;
        c_wdata = cell_value;
        alu_ctl.op      = sat_pkg::ALU_HOLD;
        alu_ctl.operand = p_rdata;

        // result beat leaves
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                p_we    = 1'b1;
                p_addr  = clr_reg;
                p_wdata = '0;
                if (clr_reg < sat_pkg::CDEPTH) begin
                    c_we    = 1'b1;
                    c_addr  = clr_reg[CAW-1:0];
                    c_wdata = '0;
                end
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        sat_pkg::OP_WRITE: begin
                            if (wr_in_range) begin
                                c_we       = 1'b1;
                                c_addr     = sat_pkg::cell_addr(RIW'(row_a), CIW'(col_a));
                                built_next = 1'b0;
                            end
                        end
                        sat_pkg::OP_BUILD: begin
                            alu_ctl.op = sat_pkg::ALU_CLR;
                            br_next    = ROW_ONE;
                            bc_next    = COL_ONE;
                            state_next = ST_BUP;
                        end
                        sat_pkg::OP_QUERY: begin
                            r1_next    = sat_pkg::clamp_row({1'b0, row_a});
                            c1_next    = sat_pkg::clamp_col({1'b0, col_a});
                            r2_next    = sat_pkg::clamp_row({1'b0, row_b} + 1'b1);
                            c2_next    = sat_pkg::clamp_col({1'b0, col_b} + 1'b1);
                            state_next = ST_QRD0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // query: P[r2][c2] - P[r1][c2] - P[r2][c1] + P[r1][c1]
            ST_QRD0: begin
                p_re       = 1'b1;
                p_addr     = sat_pkg::prefix_addr(r2_reg, c2_reg);
                state_next = ST_QRD1;
            end
            ST_QRD1: begin
                p_re       = 1'b1;
                p_addr     = sat_pkg::prefix_addr(r1_reg, c2_reg);
                alu_ctl.op = sat_pkg::ALU_LOAD;
                state_next = ST_QRD2;
            end
            ST_QRD2: begin
                p_re       = 1'b1;
                p_addr     = sat_pkg::prefix_addr(r2_reg, c1_reg);
                alu_ctl.op = sat_pkg::ALU_SUB;
                state_next = ST_QRD3;
            end
            ST_QRD3: begin
                p_re       = 1'b1;
                p_addr     = sat_pkg::prefix_addr(r1_reg, c1_reg);
                alu_ctl.op = sat_pkg::ALU_SUB;
                state_next = ST_QADD;
            end
            ST_QADD: begin
                alu_ctl.op = sat_pkg::ALU_ADD;
                state_next = ST_QDONE;
            end
            ST_QDONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_sum_next    = sat_pkg::sum_wrap(acc);
                    m_cur_next    = built_reg;
                    state_next    = ST_IDLE;
                end
            end
            // build: acc holds P[r][c-1]; add above, subtract diagonal, add cell
            ST_BUP: begin
                p_re       = 1'b1;
                p_addr     = sat_pkg::prefix_addr(br_prev, bc_reg);
                c_re       = 1'b1;
                c_addr     = sat_pkg::cell_addr(br_prev, bc_prev);
                state_next = ST_BDG;
            end
            ST_BDG: begin
                p_re       = 1'b1;
                p_addr     = sat_pkg::prefix_addr(br_prev, bc_prev);
                alu_ctl.op = sat_pkg::ALU_ADD;
                state_next = ST_BSUB;
            end
            ST_BSUB: begin
                alu_ctl.op = sat_pkg::ALU_SUB;
                state_next = ST_BADD;
            end
            ST_BADD: begin
                alu_ctl.op      = sat_pkg::ALU_ADD;
                alu_ctl.operand = sat_pkg::cell_ext(c_rdata);
                state_next      = ST_BWR;
            end
            ST_BWR: begin
                p_we   = 1'b1;
                p_addr = sat_pkg::prefix_addr(br_reg, bc_reg);
                if (bc_reg == COL_LAST) begin
                    bc_next    = COL_ONE;
                    alu_ctl.op = sat_pkg::ALU_CLR;
                    if (br_reg == ROW_LAST) begin
                        built_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        br_next    = br_reg + 1'b1;
                        state_next = ST_BUP;
                    end
                end else begin
                    bc_next    = bc_reg + 1'b1;
                    state_next = ST_BUP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            built_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            built_reg    <= built_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        r1_reg    <= r1_next;
        c1_reg    <= c1_next;
        r2_reg    <= r2_next;
        c2_reg    <= c2_next;
        br_reg    <= br_next;
        bc_reg    <= bc_next;
        m_sum_reg <= m_sum_next;
        m_cur_reg <= m_cur_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_sum_reg;
    assign m_tuser  = m_cur_reg;

`ifndef SYNTH
    // a result only appears straight out of the final query step
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_QDONE))
        else $error("result beat raised outside the query finish step");

    // a stalled result is never overwritten by the next query
    a_query_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QDONE && m_tvalid_reg && !m_tready) |=> state_reg == ST_QDONE)
        else $error("query finished over a waiting result");

    // an accepted cell write marks the table stale
    a_write_stales: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_op == sat_pkg::OP_WRITE && wr_in_range) |=> !built_reg)
        else $error("table still current after a cell write");

    // the last entry written ends the build and marks the table current
    a_build_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BWR && br_reg == ROW_LAST && bc_reg == COL_LAST)
        |=> (built_reg && state_reg == ST_IDLE))
        else $error("build did not finish on the last entry");

    // no input beat is taken in the clearing pass, the build write or the query finish
    a_ready_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR || state_reg == ST_BWR || state_reg == ST_QDONE)
        |-> !s_tready)
        else $error("input ready while busy");
`endif

endmodule

@@ src/sat_ram.sv @@
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single port, registered read that holds while idle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wr_data;
        end
        if (re) begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/sat_alu.sv @@
module sat_alu (
    input  logic                      aclk,
    input  sat_pkg::alu_ctl_t         ctl,
    output logic [sat_pkg::PW-1:0]    acc
);

    logic [sat_pkg::PW-1:0] acc_reg;
    logic [sat_pkg::PW-1:0] acc_next;

    // shared clear, load, add and subtract onto the accumulator
    always_comb begin
        case (ctl.op)
            sat_pkg::ALU_HOLD: acc_next = acc_reg;
            sat_pkg::ALU_CLR:  acc_next = '0;
            sat_pkg::ALU_LOAD: acc_next = ctl.operand;
            sat_pkg::ALU_ADD:  acc_next = acc_reg + ctl.operand;
            sat_pkg::ALU_SUB:  acc_next = acc_reg - ctl.operand;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ verif/sat_rect_checker.sv @@
module sat_rect_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // row_a, col_a, row_b, col_b, cell_value
    input  logic [1:0]  s_tuser,   // opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // rect_sum
    input  logic        m_tuser,   // table_current
    output int          mismatches,
    output int          outstanding
);

    localparam int REPORT_LIMIT = 10;
    localparam int ROWS   = sat_pkg::ROWS;
    localparam int COLS   = sat_pkg::COLS;
    localparam int CELL_W = sat_pkg::CELL_W;
    localparam int PW     = sat_pkg::PW;
    localparam int SUM_W  = sat_pkg::SUM_W;

    typedef struct packed {
        logic [SUM_W-1:0] rect_sum;
        logic             table_current;
    } rect_result_t;

    // shadow copy of the grid, the prefix table and the fresh flag
    logic signed [CELL_W-1:0] grid   [ROWS][COLS];
    logic signed [PW-1:0]     prefix [ROWS+1][COLS+1];
    logic                     table_fresh;

    rect_result_t expected_sums [$];
    rect_result_t want;
    int           miss_count = 0;

    // saturate a table coordinate
    function automatic int table_index(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void clear_tables();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                grid[r][c] = '0;
            end
        end
        for (int r = 0; r <= ROWS; r++) begin
            for (int c = 0; c <= COLS; c++) begin
                prefix[r][c] = '0;
            end
        end
        table_fresh = 1'b0;
    endfunction

    // recompute every prefix entry from the grid
    function automatic void rebuild_prefix();
        int acc;
        for (int r = 0; r <= ROWS; r++) begin
            for (int c = 0; c <= COLS; c++) begin
                if (r == 0 || c == 0) begin
                    prefix[r][c] = '0;
                end else begin
                    acc = int'(prefix[r-1][c]) + int'(prefix[r][c-1])
                        - int'(prefix[r-1][c-1]) + int'(grid[r-1][c-1]);
                    prefix[r][c] = acc[PW-1:0];
                end
            end
        end
        table_fresh = 1'b1;
    endfunction

    // inclusive rectangle sum from four table entries, stale or not
    function automatic rect_result_t rect_query(input int ra, input int ca,
                                                input int rb, input int cb);
        int           r1, c1, r2, c2, s;
        rect_result_t res;
        r1 = table_index(ra, ROWS);
        c1 = table_index(ca, COLS);
        r2 = table_index(rb + 1, ROWS);
        c2 = table_index(cb + 1, COLS);
        s = int'(prefix[r2][c2]) - int'(prefix[r1][c2])
          - int'(prefix[r2][c1]) + int'(prefix[r1][c1]);
        res.rect_sum      = s[SUM_W-1:0];
        res.table_current = table_fresh;
        return res;
    endfunction

    // advance the shadow state by one command beat
    function automatic void apply_command(input logic [1:0] op_bits, input logic [23:0] d);
        sat_pkg::opcode_t op;
        int               ra, ca;
        op = sat_pkg::opcode_t'(op_bits);
        ra = int'(d[3:0]);
        ca = int'(d[7:4]);
        case (op)
            sat_pkg::OP_WRITE: begin
                if (ra < ROWS && ca < COLS) begin
                    grid[ra][ca] = signed'(d[23:16]);
                    table_fresh  = 1'b0;
                end
            end
            sat_pkg::OP_BUILD: begin
                rebuild_prefix();
            end
            sat_pkg::OP_QUERY: begin
                expected_sums.push_back(rect_query(ra, ca, int'(d[11:8]), int'(d[15:12])));
            end
            default: begin
            end
        endcase
    endfunction

    // count a mismatch, say whether it is still worth a report line
    function automatic bit report_due();
        miss_count++;
        return miss_count <= REPORT_LIMIT;
    endfunction

    // result beats against the oldest expectation, then command beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_tables();
            expected_sums.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    if (report_due()) begin
                        $display("[%0t] result beat with nothing expected: sum %0d current %0b",
                                 $time, $signed(m_tdata), m_tuser);
                    end
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want.rect_sum || m_tuser !== want.table_current) begin
                        if (report_due()) begin
                            $display({"[%0t] result mismatch: expected sum %0d current %0b,",
                                      " got sum %0d current %0b"},
                                     $time, $signed(want.rect_sum), want.table_current,
                                     $signed(m_tdata), m_tuser);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tuser, s_tdata);
            end
        end
        mismatches  <= miss_count;
        outstanding <= expected_sums.size();
    end

endmodule

@@ verif/summed_area_table_engine_unit_test.sv @@
module summed_area_table_engine_unit_test;

    localparam int CMD_TARGET  = 800;
    localparam int CALM_TAIL   = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 250;
    localparam int DRAIN_AT    = 450;
    localparam int TAIL_CYCLES = 1400;
    localparam int STUCK_LIMIT = 8000;
    localparam int ROWS        = sat_pkg::ROWS;
    localparam int COLS        = sat_pkg::COLS;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    int mismatches;
    int outstanding;

    // stimulus side flags and tallies
    logic calm     = 1'b0;
    logic hold_req = 1'b0;
    logic hold_on  = 1'b0;
    int   cmds_sent    = 0;
    int   writes_sent  = 0;
    int   builds_sent  = 0;
    int   queries_sent = 0;
    int   unused_sent  = 0;
    int   results_seen = 0;
    int   stuck_cycles = 0;

    summed_area_table_engine_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sat_rect_checker u_rect_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STUCK_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random back-pressure bursts, one long hold on request
    initial begin : result_sink
        int n;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_on = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                hold_on  = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 7);
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic sender_gap(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // offer one command beat and wait for it to be taken
    task automatic send_cmd(input sat_pkg::opcode_t op,
                            input logic [3:0] ra, input logic [3:0] ca,
                            input logic [3:0] rb, input logic [3:0] cb,
                            input logic [7:0] cv);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cv, cb, rb, ca, ra};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (op)
            sat_pkg::OP_WRITE: writes_sent++;
            sat_pkg::OP_BUILD: builds_sent++;
            sat_pkg::OP_QUERY: queries_sent++;
            default:           unused_sent++;
        endcase
        if (op != sat_pkg::OP_NONE) begin
            cmds_sent++;
        end
        if (!calm && $urandom_range(0, 5) == 0) begin
            sender_gap($urandom_range(1, 7));
        end
    endtask

    // stop offering until every query has been answered
    task automatic await_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // cell value with the extremes well represented
    function automatic logic [7:0] pick_cell();
        case ($urandom_range(0, 7))
            0:       return 8'h7F;
            1:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic put_cell(input logic [3:0] r, input logic [3:0] c, input logic [7:0] v);
        send_cmd(sat_pkg::OP_WRITE, r, c, 4'($urandom), 4'($urandom), v);
    endtask

    task automatic run_build();
        send_cmd(sat_pkg::OP_BUILD, 4'($urandom), 4'($urandom), 4'($urandom),
                 4'($urandom), 8'($urandom));
    endtask

    task automatic ask_rect(input logic [3:0] ra, input logic [3:0] ca,
                            input logic [3:0] rb, input logic [3:0] cb);
        send_cmd(sat_pkg::OP_QUERY, ra, ca, rb, cb, 8'($urandom));
    endtask

    task automatic ask_ordered_rect();
        int r1, c1;
        r1 = $urandom_range(0, ROWS - 1);
        c1 = $urandom_range(0, COLS - 1);
        ask_rect(4'(r1), 4'(c1), 4'($urandom_range(ROWS - 1, r1)),
                 4'($urandom_range(COLS - 1, c1)));
    endtask

    task automatic put_random_cell();
        put_cell(4'($urandom_range(0, ROWS - 1)), 4'($urandom_range(0, COLS - 1)),
                 pick_cell());
    endtask

    initial begin : stimulus
        int  kind;
        int  n;
        bit  did_hold;
        bit  did_drain;
        did_hold  = 1'b0;
        did_drain = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: stale table, corner cells, extremes, inverted rectangles
        ask_rect(4'd0, 4'd0, 4'd15, 4'd15);
        send_cmd(sat_pkg::OP_NONE, 4'hF, 4'hF, 4'hF, 4'hF, 8'hFF);
        put_cell(4'd0, 4'd0, 8'h80);
        put_cell(4'd15, 4'd15, 8'h7F);
        put_cell(4'd0, 4'd15, 8'h7F);
        put_cell(4'd15, 4'd0, 8'h80);
        put_cell(4'd7, 4'd8, 8'h55);
        ask_rect(4'd0, 4'd0, 4'd15, 4'd15);
        run_build();
        ask_rect(4'd0, 4'd0, 4'd15, 4'd15);
        ask_rect(4'd15, 4'd15, 4'd15, 4'd15);
        ask_rect(4'd0, 4'd0, 4'd0, 4'd0);
        ask_rect(4'd15, 4'd15, 4'd0, 4'd0);
        ask_rect(4'd15, 4'd0, 4'd0, 4'd15);
        put_cell(4'd3, 4'd4, 8'hFF);
        ask_rect(4'd0, 4'd0, 4'd15, 4'd15);
        run_build();
        ask_rect(4'd3, 4'd4, 4'd3, 4'd4);
        run_build();
        ask_rect(4'd7, 4'd0, 4'd7, 4'd15);
        send_cmd(sat_pkg::OP_NONE, 4'h0, 4'h0, 4'h0, 4'h0, 8'h00);
        ask_rect(4'd0, 4'd0, 4'd15, 4'd15);

        // random: mostly fill, build and look sequences, some noise
        while (cmds_sent < CMD_TARGET) begin
            if (cmds_sent >= CMD_TARGET - CALM_TAIL) begin
                calm = 1'b1;
            end
            // long receiver hold while queries keep coming
            if (!did_hold && cmds_sent >= HOLD_AT) begin
                did_hold = 1'b1;
                hold_req = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (!hold_on) @(posedge aclk);
                repeat (12) ask_ordered_rect();
            end
            // sender pause until every answer is in
            if (!did_drain && cmds_sent >= DRAIN_AT) begin
                did_drain = 1'b1;
                await_results();
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(1, 12);
                    repeat (n) put_random_cell();
                    run_build();
                    n = $urandom_range(1, 6);
                    repeat (n) ask_ordered_rect();
                end
                5: begin
                    put_random_cell();
                    ask_ordered_rect();
                    ask_ordered_rect();
                end
                6: begin
                    repeat (4) ask_rect(4'($urandom), 4'($urandom), 4'($urandom),
                                        4'($urandom));
                end
                7: begin
                    repeat (3) send_cmd(sat_pkg::opcode_t'(2'($urandom)), 4'($urandom),
                                        4'($urandom), 4'($urandom), 4'($urandom),
                                        8'($urandom));
                end
                8: begin
                    run_build();
                    n = $urandom_range(2, 8);
                    repeat (n) ask_ordered_rect();
                end
                default: begin
                    send_cmd(sat_pkg::OP_NONE, 4'($urandom), 4'($urandom), 4'($urandom),
                             4'($urandom), 8'($urandom));
                    n = $urandom_range(1, 3);
                    repeat (n) ask_ordered_rect();
                end
            endcase
        end

        // drain, then give a late or stray beat time to show up
        await_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d writes, %0d builds, %0d queries and %0d unused-opcode beats",
                 writes_sent, builds_sent, queries_sent, unused_sent);
        $display("%0d results checked, with one long output hold and one full drain",
                 results_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ summed_area_table_engine_unit.f @@
src/sat_pkg.sv
src/sat_ram.sv
src/sat_alu.sv
src/summed_area_table_engine_unit.sv
verif/sat_rect_checker.sv
verif/summed_area_table_engine_unit_test.sv
